// ----- design/bgr_pkg.sv -----
package bgr_pkg;

  // Item opcodes
  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Configuration register indexes
  localparam logic [0:0] REG_GRID_SIDE = 1'b0;
  localparam logic [0:0] REG_TEX_RES   = 1'b1;

  localparam int CfgAddrBits = 1;
  localparam int CfgDataBits = 11;
  localparam int FracBits    = 16;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;      // latch sample fields, start mapping
    logic       div_start; // start both axis divisions
    logic       rd_en;     // issue a corner read
    logic [1:0] rd_sel;    // which corner
    logic       lerp_go;   // run blend stage
    logic [1:0] lerp_sel;  // 0: top, 1: bottom, 2: vertical
    logic       fin;       // form result into output register
  } bgr_cmd_t;

  typedef struct packed {
    logic div_done;
  } bgr_sts_t;

endpackage

// ----- design/bgr_if.sv -----
interface bgr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [6:0]  grid_u;
  logic [6:0]  grid_v;
  logic [31:0] load_x;
  logic [31:0] load_y;
  logic [31:0] load_z;
  logic [9:0]  texel_x;
  logic [9:0]  texel_y;
  logic [31:0] cur_x;
  logic [31:0] cur_y;
  logic [31:0] cur_z;
  modport source (output valid, op, grid_u, grid_v, load_x, load_y, load_z,
                  texel_x, texel_y, cur_x, cur_y, cur_z, input ready);
  modport sink (input valid, op, grid_u, grid_v, load_x, load_y, load_z,
                texel_x, texel_y, cur_x, cur_y, cur_z, output ready);
endinterface

interface bgr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_x;
  logic [31:0] new_y;
  logic [31:0] new_z;
  logic        texel_written;
  logic        saturated;
  modport source (output valid, new_x, new_y, new_z, texel_written, saturated,
                  input ready);
  modport sink (input valid, new_x, new_y, new_z, texel_written, saturated,
                output ready);
endinterface

// ----- design/bgr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bgr_div import bgr_pkg::*; #(
  parameter int NumBits = 30,
  parameter int DenBits = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NumBits-1:0] num,
  input  logic [DenBits-1:0] den,
  output logic               done,
  output logic [NumBits-1:0] quo,
  output logic [DenBits-1:0] rem
);
  localparam int CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] shreg;
  logic [DenBits:0]   part;
  logic [DenBits-1:0] dv;
  logic [CntBits-1:0] cnt;
  logic               busy;
  logic [DenBits:0]   trial;
  logic [DenBits:0]   diff;

  always_comb begin
    trial = {part[DenBits-1:0], shreg[NumBits-1]};
    diff  = trial - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CntBits'(NumBits);
        shreg <= num;
        dv    <= den;
        part  <= '0;
      end else if (busy) begin
        if (!diff[DenBits]) begin
          part  <= diff;
          shreg <= {shreg[NumBits-2:0], 1'b1};
        end else begin
          part  <= trial;
          shreg <= {shreg[NumBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = shreg;
  assign rem = part[DenBits-1:0];
endmodule

// ----- design/bgr_datapath.sv -----
// Grid store, axis mapping, bilinear blend and saturation.
module bgr_datapath import bgr_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_RES    = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  bgr_cmd_t      cmd,
  output bgr_sts_t      sts,
  // load write
  input  logic          wr_en,
  input  logic [6:0]    grid_u,
  input  logic [6:0]    grid_v,
  input  logic [31:0]   load_x,
  input  logic [31:0]   load_y,
  input  logic [31:0]   load_z,
  // sample fields
  input  logic [9:0]    texel_x,
  input  logic [9:0]    texel_y,
  input  logic [31:0]   cur_x,
  input  logic [31:0]   cur_y,
  input  logic [31:0]   cur_z,
  // configuration
  input  logic [6:0]    grid_side,
  input  logic [10:0]   tex_res,
  // result
  output logic [31:0]   new_x,
  output logic [31:0]   new_y,
  output logic [31:0]   new_z,
  output logic          texel_written,
  output logic          saturated
);
  localparam int Stride   = MAX_SIDE + 1;
  localparam int Depth    = Stride * Stride;
  localparam int AddrBits = $clog2(Depth);
  localparam int SBits    = $clog2(MAX_SIDE + 1);
  localparam int RBits    = $clog2(MAX_RES + 1);
  localparam int TBits    = 10;
  localparam int NBits    = RBits + 1 + SBits + FracBits;
  localparam int DBits    = RBits + 1;
  localparam int SatBits  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic signed [33:0] SatHi = 34'sd2 ** (SatBits - 1) - 34'sd1;
  localparam logic signed [33:0] SatLo = -SatHi - 34'sd1;

  logic [31:0] mem_x [Depth];
  logic [31:0] mem_y [Depth];
  logic [31:0] mem_z [Depth];
  logic [31:0] rd_x, rd_y, rd_z;

  // Clamped configuration
  logic [SBits-1:0] s_eff;
  logic [RBits-1:0] r_eff;
  always_comb begin
    if (grid_side == 7'd0) s_eff = SBits'(1);
    else if (32'(grid_side) > MAX_SIDE) s_eff = SBits'(MAX_SIDE);
    else s_eff = SBits'(grid_side);
    if (tex_res == 11'd0) r_eff = RBits'(1);
    else if (32'(tex_res) > MAX_RES) r_eff = RBits'(MAX_RES);
    else r_eff = RBits'(tex_res);
  end

  // Sample latch
  logic [TBits-1:0] tx, ty;
  logic [31:0] cx, cy, cz;
  logic [SBits-1:0] s_l;
  logic [RBits-1:0] r_l;
  logic [TBits-1:0] tx_c, ty_c;
  always_comb begin
    tx_c = (32'(tx) >= 32'(r_l)) ? TBits'(r_l - 1'b1) : tx;
    ty_c = (32'(ty) >= 32'(r_l)) ? TBits'(r_l - 1'b1) : ty;
  end

  // Divide ((2t+1)*S << 16) by 2R; quotient high bits are cell, low bits frac
  logic [NBits-1:0] numx, numy;
  logic [DBits-1:0] den;
  always_comb begin
    numx = NBits'((({NBits'(tx_c), 1'b1} * NBits'(s_l)) << FracBits));
    numy = NBits'((({NBits'(ty_c), 1'b1} * NBits'(s_l)) << FracBits));
    den  = {r_l, 1'b0};
  end

  logic             dx_done, dy_done;
  logic [NBits-1:0] qx, qy;
  logic [DBits-1:0] remx, remy;
  bgr_div #(.NumBits(NBits), .DenBits(DBits)) u_divx (
    .clk, .rst, .start(cmd.div_start), .num(numx), .den,
    .done(dx_done), .quo(qx), .rem(remx));
  bgr_div #(.NumBits(NBits), .DenBits(DBits)) u_divy (
    .clk, .rst, .start(cmd.div_start), .num(numy), .den,
    .done(dy_done), .quo(qy), .rem(remy));
  assign sts.div_done = dx_done;

  // Cell and fraction; clamped cell takes an all-ones fraction
  logic [NBits-FracBits-1:0] cux, cvy;
  logic [SBits-1:0] cu, cv;
  logic [FracBits-1:0] fu, fv;
  logic [FracBits-1:0] fu_r, fv_r;
  logic [AddrBits-1:0] base;
  always_comb begin
    cux = qx[NBits-1:FracBits];
    cvy = qy[NBits-1:FracBits];
    if (cux > (NBits-FracBits)'(s_l - 1'b1)) begin
      cu = s_l - 1'b1;
      fu = '1;
    end else begin
      cu = SBits'(cux);
      fu = qx[FracBits-1:0];
    end
    if (cvy > (NBits-FracBits)'(s_l - 1'b1)) begin
      cv = s_l - 1'b1;
      fv = '1;
    end else begin
      cv = SBits'(cvy);
      fv = qy[FracBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      tx <= texel_x; ty <= texel_y;
      cx <= cur_x; cy <= cur_y; cz <= cur_z;
      s_l <= s_eff; r_l <= r_eff;
    end
    if (sts.div_done) begin
      fu_r <= fu; fv_r <= fv;
      base <= AddrBits'(32'(cv) * Stride + 32'(cu));
    end
  end

  // Store: one write or one read per cycle
  logic [AddrBits-1:0] rd_addr, wr_addr;
  always_comb begin
    wr_addr = AddrBits'(32'(grid_v) * Stride + 32'(grid_u));
    case (cmd.rd_sel)
      2'd0:    rd_addr = base;
      2'd1:    rd_addr = base + AddrBits'(1);
      2'd2:    rd_addr = base + AddrBits'(Stride);
      default: rd_addr = base + AddrBits'(Stride + 1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= load_x;
      mem_y[wr_addr] <= load_y;
      mem_z[wr_addr] <= load_z;
    end
    if (cmd.rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
      rd_z <= mem_z[rd_addr];
    end
  end

  // Corner holding registers; blend stage: a*(1-f) + b*f, floored
  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic signed [32:0] top_x, top_y, top_z, bot_x, bot_y, bot_z;
  logic signed [32:0] la_x, la_y, la_z, lb_x, lb_y, lb_z;
  logic [16:0] f_one;
  logic [FracBits-1:0] f_sel;
  logic signed [32:0] lo_x, lo_y, lo_z;
  logic signed [32:0] d_x, d_y, d_z;

  function automatic logic signed [32:0] lerp(input logic signed [32:0] a,
      input logic signed [32:0] b, input logic [FracBits-1:0] f);
    logic signed [51:0] p;
    p = 52'(a) * $signed({35'd0, 17'(17'h10000 - {1'b0, f})})
      + 52'(b) * $signed({36'd0, f});
    return 33'(p >>> FracBits);
  endfunction

  always_comb begin
    f_sel = (cmd.lerp_sel == 2'd2) ? fv_r : fu_r;
    f_one = 17'h10000 - {1'b0, f_sel};
    case (cmd.lerp_sel)
      2'd2: begin
        la_x = top_x; la_y = top_y; la_z = top_z;
        lb_x = bot_x; lb_y = bot_y; lb_z = bot_z;
      end
      default: begin
        la_x = 33'(a_x); la_y = 33'(a_y); la_z = 33'(a_z);
        lb_x = 33'(b_x); lb_y = 33'(b_y); lb_z = 33'(b_z);
      end
    endcase
    lo_x = lerp(la_x, lb_x, f_sel);
    lo_y = lerp(la_y, lb_y, f_sel);
    lo_z = lerp(la_z, lb_z, f_sel);
  end

  // Corner reads pass through rd_x/y/z into a/b; even corners into a, odd into b
  logic       rd_v;
  logic [1:0] rd_s;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.rd_en;
    end
    rd_s <= cmd.rd_sel;
    if (rd_v) begin
      if (!rd_s[0]) begin
        a_x <= rd_x; a_y <= rd_y; a_z <= rd_z;
      end else begin
        b_x <= rd_x; b_y <= rd_y; b_z <= rd_z;
      end
    end
    if (cmd.lerp_go) begin
      case (cmd.lerp_sel)
        2'd0: begin top_x <= lo_x; top_y <= lo_y; top_z <= lo_z; end
        2'd1: begin bot_x <= lo_x; bot_y <= lo_y; bot_z <= lo_z; end
        default: begin d_x <= lo_x; d_y <= lo_y; d_z <= lo_z; end
      endcase
    end
  end

  // Sum and saturate
  logic signed [33:0] s_x, s_y, s_z;
  logic clip_x, clip_y, clip_z;
  logic [31:0] o_x, o_y, o_z;
  always_comb begin
    s_x = 34'($signed(cx)) + 34'(d_x);
    s_y = 34'($signed(cy)) + 34'(d_y);
    s_z = 34'($signed(cz)) + 34'(d_z);
    clip_x = (s_x > SatHi) || (s_x < SatLo);
    clip_y = (s_y > SatHi) || (s_y < SatLo);
    clip_z = (s_z > SatHi) || (s_z < SatLo);
    o_x = (s_x > SatHi) ? 32'(SatHi) : (s_x < SatLo) ? 32'(SatLo) : 32'(s_x);
    o_y = (s_y > SatHi) ? 32'(SatHi) : (s_y < SatLo) ? 32'(SatLo) : 32'(s_y);
    o_z = (s_z > SatHi) ? 32'(SatHi) : (s_z < SatLo) ? 32'(SatLo) : 32'(s_z);
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      new_x <= o_x; new_y <= o_y; new_z <= o_z;
      texel_written <= (d_x != '0) || (d_y != '0) || (d_z != '0);
      saturated <= clip_x || clip_y || clip_z;
    end
  end

  // f_one and dy_done, remainders kept for the frac check below
  assert property (@(posedge clk) disable iff (rst) dx_done == dy_done)
    else $error("axis dividers out of step");
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !dx_done)
    else $error("divider done right after start");
  assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (remx < den) && (remy < den) && (f_one != 17'd0))
    else $error("remainder not below divisor");
endmodule

// ----- design/bgr_ctrl.sv -----
// Sequencer: a load is written on acceptance; a sample divides, reads four corners, blends.
module bgr_ctrl import bgr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     wr_en,
  output logic     out_valid,
  input  logic     out_ready,
  output bgr_cmd_t cmd,
  input  bgr_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_WAIT, S_RD0, S_RD1, S_RD2, S_RD3, S_GAP, S_LT, S_LB, S_LV, S_FIN
  } state_t;

  state_t state;
  logic   accept;
  logic   fin_ok;

  // New item whenever idle; a finished sample waits for the output register
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign wr_en    = accept && (in_op == OP_LOAD);
  assign fin_ok   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.take      = accept && (in_op == OP_SAMPLE);
    cmd.div_start = (state == S_DIV);
    case (state)
      S_RD0: begin cmd.rd_en = 1'b1; cmd.rd_sel = 2'd0; end
      S_RD1: begin cmd.rd_en = 1'b1; cmd.rd_sel = 2'd1; end
      S_RD2: begin cmd.rd_en = 1'b1; cmd.rd_sel = 2'd2; end
      S_RD3: begin cmd.rd_en = 1'b1; cmd.rd_sel = 2'd3; end
      S_LT:  begin cmd.lerp_go = 1'b1; cmd.lerp_sel = 2'd0; end
      S_LB:  begin cmd.lerp_go = 1'b1; cmd.lerp_sel = 2'd1; end
      S_LV:  begin cmd.lerp_go = 1'b1; cmd.lerp_sel = 2'd2; end
      S_FIN: cmd.fin = fin_ok;
      default: ;
    endcase
  end

  // A corner passes through the read register into a/b: corners 0/1 are held
  // in LT, corner 2 lands at the end of LT and corner 3 at the end of GAP
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin_ok) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:  if (accept && in_op == OP_SAMPLE) state <= S_DIV;
        S_DIV:   state <= S_WAIT;
        S_WAIT:  if (sts.div_done) state <= S_RD0;
        S_RD0:   state <= S_RD1;
        S_RD1:   state <= S_RD2;
        S_RD2:   state <= S_LT;
        S_LT:    state <= S_RD3;
        S_RD3:   state <= S_GAP;
        S_GAP:   state <= S_LB;
        S_LB:    state <= S_LV;
        S_LV:    state <= S_FIN;
        S_FIN:   if (fin_ok) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> out_valid)
    else $error("result lost at finish");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");
  assert property (@(posedge clk) disable iff (rst)
    cmd.lerp_go |-> !cmd.rd_en)
    else $error("read and blend in one cycle");
endmodule

// ----- design/bilinear_grid_resampler_unit.sv -----
// Channel  Dir  Fields
// in       in   op grid_u grid_v load_x/y/z texel_x/y cur_x/y/z
// out      out  new_x/y/z texel_written saturated
// cfg      in   cfg_we cfg_index cfg_data (0 grid_side, 1 tex_res)
//
// A load item is written on acceptance and gives no result.
// A sample starts both axis dividers in the DIV state, waits while they
// produce one quotient bit a cycle, then makes four single-port corner
// reads, spends the GAP state on the last corner landing and runs three
// blend steps before its result is formed in the output register.
// Reset is synchronous; the grid store is not cleared.
// A held result stalls only the finish of the next sample; loads pass only while no sample is in progress.
module bilinear_grid_resampler_unit import bgr_pkg::*; #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_RES    = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  bgr_in_if.sink                 in_ch,
  bgr_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CfgAddrBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data
);
  logic [6:0]  grid_side;
  logic [10:0] tex_res;
  bgr_cmd_t    cmd;
  bgr_sts_t    sts;
  logic        wr_raw, wr_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= 7'd1;
      tex_res   <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIDE: grid_side <= cfg_data[6:0];
        REG_TEX_RES:   tex_res   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Loads beyond the grid are dropped
  assign wr_en = wr_raw && (32'(in_ch.grid_u) <= MAX_SIDE)
                        && (32'(in_ch.grid_v) <= MAX_SIDE);

  bgr_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_op(in_ch.op), .in_ready(in_ch.ready),
    .wr_en(wr_raw), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts);

  bgr_datapath #(.MAX_SIDE(MAX_SIDE), .MAX_RES(MAX_RES),
                 .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .wr_en,
    .grid_u(in_ch.grid_u), .grid_v(in_ch.grid_v),
    .load_x(in_ch.load_x), .load_y(in_ch.load_y), .load_z(in_ch.load_z),
    .texel_x(in_ch.texel_x), .texel_y(in_ch.texel_y),
    .cur_x(in_ch.cur_x), .cur_y(in_ch.cur_y), .cur_z(in_ch.cur_z),
    .grid_side, .tex_res,
    .new_x(out_ch.new_x), .new_y(out_ch.new_y), .new_z(out_ch.new_z),
    .texel_written(out_ch.texel_written), .saturated(out_ch.saturated));
endmodule
